### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain invariant, sampled on clk, off during reset.
`define UCP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Implication from a trigger to a consequence in the same cycle.
`define UCP_ASSERT_IMPL(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed");
`else
`define UCP_ASSERT(lbl, cond)
`define UCP_ASSERT_IMPL(lbl, trig, cons)
`endif

`endif

### hdl/ucp_pkg.sv
// ---------------------------------------------------------------------------
// ucp_pkg
// Types and widths for the unit normal (normalized cross product) pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucp_pkg;

  localparam int unsigned SW    = 64;  // squared length
  localparam int unsigned RW    = 92;  // |c|^2 * 2^30
  localparam int unsigned PW    = 97;  // (2q-1)^2 * S
  localparam int unsigned QSW   = 82;  // (2q-1) * S, signed
  localparam int unsigned QBITS = 15;  // result magnitude 0..16384

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;
    logic signed [15:0] n_z;
    logic               degenerate;
  } out_t;

  // One component during the magnitude search.
  typedef struct packed {
    logic [PW-1:0]         p;
    logic signed [QSW-1:0] qs;
    logic [QBITS-1:0]      q;
    logic [RW-1:0]         r;
    logic                  neg;
  } lane_t;

  typedef struct packed {
    lane_t         lx;
    lane_t         ly;
    lane_t         lz;
    logic [SW-1:0] s;
    logic          deg;
  } step_t;

endpackage

### hdl/ucp_norm_step.sv
// ---------------------------------------------------------------------------
// ucp_norm_step
// One registered bit decision of the rounded c/|c| magnitude, three lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucp_norm_step
  import ucp_pkg::*;
#(
  parameter int unsigned BIT = 14
) (
  input  logic  clk,
  input  logic  en,
  input  step_t d_in,
  output step_t d_out_r
);

  // Try q + 2^BIT: (2q'-1)^2 S = P + 2^(BIT+2) Q + 2^(2BIT+2) S, Q' = Q + 2^(BIT+1) S.
  function automatic lane_t step_lane(lane_t li, logic [SW-1:0] s);
    logic signed [PW+1:0] p_ext;
    logic signed [PW+1:0] q_ext;
    logic signed [PW+1:0] s_ext;
    logic signed [PW+1:0] p_try;
    logic signed [QSW-1:0] s_q;
    lane_t lo;
    p_ext = $signed({2'b00, li.p});
    q_ext = $signed({{(PW+2-QSW){li.qs[QSW-1]}}, li.qs});
    s_ext = $signed({{(PW+2-SW){1'b0}}, s});
    s_q   = $signed({{(QSW-SW){1'b0}}, s});
    p_try = p_ext + (q_ext <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
    lo = li;
    if (!p_try[PW+1] && (p_try[PW-1:0] <= {{(PW-RW){1'b0}}, li.r})) begin
      lo.p  = p_try[PW-1:0];
      lo.qs = li.qs + (s_q <<< (BIT + 1));
      lo.q  = li.q | (QBITS'(1) << BIT);
    end
    return lo;
  endfunction

  step_t d_nxt;

  always_comb begin
    d_nxt     = d_in;
    d_nxt.lx  = step_lane(d_in.lx, d_in.s);
    d_nxt.ly  = step_lane(d_in.ly, d_in.s);
    d_nxt.lz  = step_lane(d_in.lz, d_in.s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end

endmodule

### hdl/unit_normal_from_cross_product.sv
// ---------------------------------------------------------------------------
// unit_normal_from_cross_product
// Unit normal n = (a x b) / |a x b| in Q1.14 from two Q8.8 vectors.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one item: vectors a and b, signed Q8.8.
//   out_valid/out_ready/out_data carry one result item: n_x, n_y, n_z in
//   signed Q1.14 (rounded to nearest, ties away from zero) and degenerate.
//   There are 21 register stages, the input register included. Throughput is
//   one item per cycle while out_ready is high, since every stage can then
//   load in every cycle.
//   Stages: input reg, six 16x16 products, cross difference, three 32x32
//   squares, length sum, 15 bit steps of the magnitude search (one result
//   bit per stage, shift-and-add only), output register.
//   The cross product being zero gives zero components and degenerate = 1.
//   When out_ready is low, bubbles still collapse: a stage loads whenever it
//   is empty or the stage after it moves, so in_ready only drops once every
//   stage holds an item. Nothing is lost or repeated across a stall.
//   Reset (rst_n low, synchronous) empties all stages; no item state is kept.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module unit_normal_from_cross_product
  import ucp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned NST = 21;   // pipeline stages incl. output
  localparam int unsigned SRC = 5;    // first search stage

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] rdy;

  // Stage ready: empty, or the next stage takes the item this cycle.
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) v_nxt[0] = in_valid;
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];

  // stage 0: input register
  in_t in_r;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      in_r <= in_data;
    end
  end

  // stage 1: the six products
  logic signed [31:0] p_aybz_r, p_azby_r, p_azbx_r, p_axbz_r, p_axby_r, p_aybx_r;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_aybz_r <= in_r.a_y * in_r.b_z;
      p_azby_r <= in_r.a_z * in_r.b_y;
      p_azbx_r <= in_r.a_z * in_r.b_x;
      p_axbz_r <= in_r.a_x * in_r.b_z;
      p_axby_r <= in_r.a_x * in_r.b_y;
      p_aybx_r <= in_r.a_y * in_r.b_x;
    end
  end

  // stage 2: cross product, kept as sign and magnitude (|c| < 2^31)
  logic signed [32:0] cx, cy, cz;
  logic [31:0] mx_r, my_r, mz_r;
  logic nx_r, ny_r, nz_r;
  assign cx = 33'(p_aybz_r) - 33'(p_azby_r);
  assign cy = 33'(p_azbx_r) - 33'(p_axbz_r);
  assign cz = 33'(p_axby_r) - 33'(p_aybx_r);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      nx_r <= cx[32];
      ny_r <= cy[32];
      nz_r <= cz[32];
      mx_r <= cx[32] ? 32'(-cx) : cx[31:0];
      my_r <= cy[32] ? 32'(-cy) : cy[31:0];
      mz_r <= cz[32] ? 32'(-cz) : cz[31:0];
    end
  end

  // stage 3: squares (each below 2^62)
  logic [63:0] sqx_r, sqy_r, sqz_r;
  logic sx_r, sy_r, sz_r;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sqx_r <= mx_r * mx_r;
      sqy_r <= my_r * my_r;
      sqz_r <= mz_r * mz_r;
      sx_r  <= nx_r;
      sy_r  <= ny_r;
      sz_r  <= nz_r;
    end
  end

  // stage 4: squared length, search seeded at q = 0 with P = S, Q = -S
  logic [SW+1:0] s_sum;
  logic [SW-1:0] s_len;
  step_t chain [QBITS+1];
  step_t seed_nxt;
  assign s_sum = {2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r};
  assign s_len = s_sum[SW-1:0];

  function automatic lane_t seed_lane(logic [63:0] sq, logic neg, logic [SW-1:0] s);
    lane_t l;
    l.p   = {{(PW-SW){1'b0}}, s};
    l.qs  = -$signed({{(QSW-SW){1'b0}}, s});
    l.q   = '0;
    l.r   = {sq[61:0], 30'b0};
    l.neg = neg;
    return l;
  endfunction

  always_comb begin
    seed_nxt.lx  = seed_lane(sqx_r, sx_r, s_len);
    seed_nxt.ly  = seed_lane(sqy_r, sy_r, s_len);
    seed_nxt.lz  = seed_lane(sqz_r, sz_r, s_len);
    seed_nxt.s   = s_len;
    seed_nxt.deg = (s_len == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy[SRC-1]) begin
      chain[0] <= seed_nxt;
    end
  end

  // stages 5..19: one result bit per stage, MSB first
  for (genvar i = 0; i < QBITS; i++) begin : g_step
    ucp_norm_step #(
      .BIT(QBITS - 1 - i)
    ) u_step (
      .clk    (clk),
      .en     (rdy[SRC+i]),
      .d_in   (chain[i]),
      .d_out_r(chain[i+1])
    );
  end

  // stage 20: output register, sign applied after rounding
  function automatic logic signed [15:0] signed_mag(lane_t l, logic deg);
    logic signed [15:0] m;
    m = $signed({1'b0, l.q});
    if (deg) return '0;
    return l.neg ? -m : m;
  endfunction

  out_t out_nxt;
  always_comb begin
    out_nxt.n_x        = signed_mag(chain[QBITS].lx, chain[QBITS].deg);
    out_nxt.n_y        = signed_mag(chain[QBITS].ly, chain[QBITS].deg);
    out_nxt.n_z        = signed_mag(chain[QBITS].lz, chain[QBITS].deg);
    out_nxt.degenerate = chain[QBITS].deg;
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_data <= out_nxt;
    end
  end

  // in_ready only drops when the pipe is full back to the output
  `UCP_ASSERT_IMPL(a_full_when_blocked, !in_ready, out_valid && !out_ready)
  // degenerate results carry zero components
  `UCP_ASSERT_IMPL(a_deg_zero, out_valid && out_data.degenerate,
                   out_data.n_x == 16'sd0 && out_data.n_y == 16'sd0 && out_data.n_z == 16'sd0)
  // unit vector components never exceed one in Q1.14
  `UCP_ASSERT_IMPL(a_range, out_valid,
                   out_data.n_x <= 16'sd16384 && out_data.n_x >= -16'sd16384 &&
                   out_data.n_y <= 16'sd16384 && out_data.n_y >= -16'sd16384 &&
                   out_data.n_z <= 16'sd16384 && out_data.n_z >= -16'sd16384)

endmodule

### tb/sv/tb_unit_normal_from_cross_product.sv
// ---------------------------------------------------------------------------
// tb_unit_normal_from_cross_product
// Self-checking bench: vector pairs in, unit normals checked against an
// exact integer predictor, with random stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_unit_normal_from_cross_product;
  import ucp_pkg::*;

  // Expected normals and the exact predictor behind them.
  class normal_scoreboard;
    out_t        pending_normals[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned degenerate_seen;

    // Largest q in 0..16384 with (2q-1)^2 * S <= (|c| * 2^15)^2.
    function automatic logic signed [15:0] scale_to_q14(longint comp, logic [63:0] len_sq);
      logic [63:0]  mag;
      logic [127:0] rhs, lhs, d;
      int           lo, hi, mid;
      mag = (comp < 0) ? -comp : comp;
      rhs = {64'd0, mag} << 15;
      rhs = rhs * rhs;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        d = 2 * mid - 1;
        lhs = d * d * {64'd0, len_sq};
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (comp < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic out_t unit_normal(in_t v);
      longint      cx, cy, cz;
      logic [63:0] len_sq;
      out_t        r;
      cx = longint'(v.a_y) * v.b_z - longint'(v.a_z) * v.b_y;
      cy = longint'(v.a_z) * v.b_x - longint'(v.a_x) * v.b_z;
      cz = longint'(v.a_x) * v.b_y - longint'(v.a_y) * v.b_x;
      len_sq = cx * cx + cy * cy + cz * cz;
      r = '0;
      if (len_sq == 0) begin
        r.degenerate = 1'b1;
      end else begin
        r.n_x = scale_to_q14(cx, len_sq);
        r.n_y = scale_to_q14(cy, len_sq);
        r.n_z = scale_to_q14(cz, len_sq);
      end
      return r;
    endfunction

    function void note_input(in_t v);
      pending_normals.push_back(unit_normal(v));
    endfunction

    function void check_result(out_t got);
      out_t exp_n;
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_n = pending_normals.pop_front();
      checked++;
      if (got.degenerate) degenerate_seen++;
      if (got.n_x !== exp_n.n_x) begin
        $display("%0t: n_x expected %0d actual %0d", $time, exp_n.n_x, got.n_x);
        errors++;
      end
      if (got.n_y !== exp_n.n_y) begin
        $display("%0t: n_y expected %0d actual %0d", $time, exp_n.n_y, got.n_y);
        errors++;
      end
      if (got.n_z !== exp_n.n_z) begin
        $display("%0t: n_z expected %0d actual %0d", $time, exp_n.n_z, got.n_z);
        errors++;
      end
      if (got.degenerate !== exp_n.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, exp_n.degenerate,
                 got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  normal_scoreboard sb;
  bit               idle_on;   // random idling on both channels
  int unsigned      pairs_sent;

  unit_normal_from_cross_product uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Send one vector pair; returns at the edge where it is accepted.
  // Handshake is sampled at the falling edge, where every signal is settled.
  // in_valid stays high after the accept; the next call or the caller drops it.
  task automatic send_pair(in_t v);
    bit taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sb.note_input(v);
    pairs_sent++;
  endtask

  function automatic in_t pair_of(int ax, int ay, int az, int bx, int by, int bz);
    in_t v;
    v.a_x = 16'(ax); v.a_y = 16'(ay); v.a_z = 16'(az);
    v.b_x = 16'(bx); v.b_y = 16'(by); v.b_z = 16'(bz);
    return v;
  endfunction

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0:       return 16'($urandom_range(0, 65535));                // full range
      1:       return 16'($signed($urandom_range(0, 1023)) - 512);  // near the origin
      default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic in_t random_pair();
    in_t v;
    int  kind, mode, k;
    kind = $urandom_range(0, 9);
    mode = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 4) == 0) ? 2 : 1);
    v.a_x = rand_comp(mode); v.a_y = rand_comp(mode); v.a_z = rand_comp(mode);
    v.b_x = rand_comp(mode); v.b_y = rand_comp(mode); v.b_z = rand_comp(mode);
    if (kind == 0) begin
      // parallel pair: b = k * a, small a so k*a stays in range
      v.a_x = rand_comp(1); v.a_y = rand_comp(1); v.a_z = rand_comp(1);
      k = $signed($urandom_range(0, 60)) - 30;
      v.b_x = 16'(v.a_x * k); v.b_y = 16'(v.a_y * k); v.b_z = 16'(v.a_z * k);
    end else if (kind == 1) begin
      // nearly axis-aligned normal: two small cross terms beside a large z term
      v.a_z = '0; v.b_z = 16'($signed($urandom_range(0, 2)) - 1);
    end
    return v;
  endfunction

  // Receiver: out_ready stalls in random bursts while idling is on.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result monitor
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Hard limit on run time
  initial begin
    #5_000_000;
    $display("[unit_normal_from_cross_product] ERROR");
    $finish;
  end

  initial begin
    in_t directed[$];
    int  wait_cycles;
    sb = new();
    idle_on = 1'b0;
    pairs_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero and parallel vectors, unit axes, full-scale extremes.
    directed.push_back(pair_of(0, 0, 0, 0, 0, 0));
    directed.push_back(pair_of(256, 512, -768, 512, 1024, -1536));
    directed.push_back(pair_of(-32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(pair_of(256, 0, 0, 0, 256, 0));
    directed.push_back(pair_of(0, 256, 0, 256, 0, 0));
    directed.push_back(pair_of(0, 0, 256, 256, 0, 0));
    directed.push_back(pair_of(0, 256, 0, 0, 0, 256));
    directed.push_back(pair_of(-32768, 0, 0, 0, -32768, 0));
    directed.push_back(pair_of(32767, 0, 0, 0, 32767, 0));
    directed.push_back(pair_of(-32768, 0, 0, 0, 32767, 0));
    directed.push_back(pair_of(32767, 32767, 32767, -32768, -32768, 32767));
    directed.push_back(pair_of(-32768, 32767, -32768, 32767, -32768, -32768));
    directed.push_back(pair_of(32767, -32768, 0, 0, 32767, -32768));
    directed.push_back(pair_of(1, 0, 0, 0, 1, 0));
    directed.push_back(pair_of(1, 1, 1, 1, 1, 2));
    directed.push_back(pair_of(-1, -1, -1, -1, -1, -1));
    directed.push_back(pair_of(256, 256, 0, 256, -256, 0));   // equal components
    directed.push_back(pair_of(256, 0, 0, 0, 256, 256));
    directed.push_back(pair_of(32767, 1, 0, 1, 32767, 0));
    directed.push_back(pair_of(0, 0, 0, 32767, -32768, 12345));
    foreach (directed[i]) send_pair(directed[i]);

    // Random with idling on both sides
    idle_on = 1'b1;
    for (int i = 0; i < 1300; i++) begin
      if (i == 600) begin
        // let the pipeline drain fully before continuing
        in_valid <= 1'b0;
        while (sb.pending_normals.size() != 0) @(posedge clk);
      end
      send_pair(random_pair());
    end

    // Last stretch back to back, no idling anywhere
    idle_on = 1'b0;
    for (int i = 0; i < 200; i++) send_pair(random_pair());
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_normals.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);

    $display("Sent %0d vector pairs, checked %0d normals (%0d degenerate), %0d errors.",
             pairs_sent, sb.checked, sb.degenerate_seen, sb.errors);
    $display("Covered extremes, parallel and zero vectors, random stalls, a full drain.");
    if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
      $display("[unit_normal_from_cross_product] OK");
    end else begin
      $display("[unit_normal_from_cross_product] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/ucp_pkg.sv
hdl/ucp_norm_step.sv
hdl/unit_normal_from_cross_product.sv
tb/sv/tb_unit_normal_from_cross_product.sv
